// ----- src/sawr_pkg.sv -----
// sawr_pkg: constants, codes and transfer types for the stop-and-wait packet receiver
// no dependencies; used by sawr_core, sawr_outq and stop_and_wait_packet_receiver_unit
`timescale 1ns / 1ps

package sawr_pkg;

  localparam int MAX_PAYLOAD = 8192;
  localparam int EXTRA_ACKS  = 10;
  localparam int HDR_BYTES   = 8;
  localparam int SIZE_BYTES  = 8;
  localparam int POS_W       = 14;

  localparam logic [POS_W-1:0] POS_CAP      = POS_W'(MAX_PAYLOAD + HDR_BYTES);
  localparam logic [POS_W-1:0] POS_HDR      = POS_W'(HDR_BYTES);
  localparam logic [POS_W-1:0] POS_SIZE_END = POS_W'(HDR_BYTES + SIZE_BYTES);
  localparam logic [POS_W-1:0] POS_SERIAL   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LENGTH   = POS_W'(6);

  localparam logic [31:0] HASH_MUL = 32'd131;

  localparam int ACK_COPIES_SUM = 1 + EXTRA_ACKS;
  localparam logic [3:0] ACK_COPIES_DONE = (ACK_COPIES_SUM > 15) ? 4'd15 : 4'(ACK_COPIES_SUM);
  localparam logic [3:0] ACK_COPIES_ONE  = 4'd1;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_NAME    = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [2:0] VERD_ACCEPTED    = 3'd0;
  localparam logic [2:0] VERD_DUP_REACKED = 3'd1;
  localparam logic [2:0] VERD_DUP_IGNORED = 3'd2;
  localparam logic [2:0] VERD_BAD_HASH    = 3'd3;
  localparam logic [2:0] VERD_BAD_LENGTH  = 3'd4;
  localparam logic [2:0] VERD_AHEAD       = 3'd5;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_datagram;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  out_byte;
    logic [2:0]  verdict;
    logic        commit;
    logic        ack_valid;
    logic [15:0] ack_serial;
    logic [3:0]  ack_copies;
    logic [63:0] announced_size;
    logic        transfer_done;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  item0;
    out_item_t  item1;
  } core_push_t;

  typedef struct packed {
    logic                  room2;
    logic [OUTQ_CNT_W-1:0] count;
  } outq_stat_t;

endpackage

// ----- src/sawr_core.sv -----
// sawr_core: header parse, running hash, payload release and packet verdict, one byte a cycle while take is high
// depends on sawr_pkg
`timescale 1ns / 1ps

module sawr_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  sawr_pkg::in_item_t    item,
  output sawr_pkg::core_push_t  push
);

  logic [15:0]               expected_serial_r, expected_serial_nxt;
  logic                      awaiting_first_r, awaiting_first_nxt;
  logic [63:0]               ann_size_r, ann_size_nxt;
  logic [63:0]               delivered_r, delivered_nxt;
  logic [sawr_pkg::POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [31:0]               run_hash_r, run_hash_nxt;
  logic [31:0]               hdr_hash_r, hdr_hash_nxt;
  logic [15:0]               hdr_serial_r, hdr_serial_nxt;
  logic [15:0]               hdr_len_r, hdr_len_nxt;
  logic [63:0]               size_shift_r, size_shift_nxt;
  logic                      finished_r, finished_nxt;

  logic                      first_pkt;
  logic                      in_win;
  logic [7:0]                b;
  logic [sawr_pkg::POS_W-1:0] cnt;
  logic                      len_bad;
  logic                      done;
  sawr_pkg::out_item_t       pay_item;
  sawr_pkg::out_item_t       verd_item;
  logic                      pay_emit;

  always_comb begin
    expected_serial_nxt = expected_serial_r;
    awaiting_first_nxt  = awaiting_first_r;
    ann_size_nxt        = ann_size_r;
    delivered_nxt       = delivered_r;
    byte_pos_nxt        = byte_pos_r;
    run_hash_nxt        = run_hash_r;
    hdr_hash_nxt        = hdr_hash_r;
    hdr_serial_nxt      = hdr_serial_r;
    hdr_len_nxt         = hdr_len_r;
    size_shift_nxt      = size_shift_r;
    finished_nxt        = finished_r;

    b         = item.rx_byte;
    first_pkt = awaiting_first_r && (expected_serial_r == 16'd0);
    in_win    = byte_pos_r < sawr_pkg::POS_CAP;
    pay_emit  = 1'b0;
    done      = 1'b0;
    cnt       = byte_pos_r;
    len_bad   = 1'b0;

    pay_item           = '0;
    pay_item.out_byte  = b;
    pay_item.item_kind = first_pkt ? sawr_pkg::KIND_NAME : sawr_pkg::KIND_PAYLOAD;

    verd_item           = '0;
    verd_item.item_kind = sawr_pkg::KIND_VERDICT;
    verd_item.last_of_run = 1'b1;

    if (take && !finished_r) begin
      if (in_win) begin
        if (byte_pos_r < sawr_pkg::POS_SERIAL) begin
          hdr_hash_nxt = {hdr_hash_r[23:0], b};
        end else if (byte_pos_r < sawr_pkg::POS_LENGTH) begin
          hdr_serial_nxt = {hdr_serial_r[7:0], b};
        end else if (byte_pos_r < sawr_pkg::POS_HDR) begin
          hdr_len_nxt = {hdr_len_r[7:0], b};
        end
        if (byte_pos_r >= sawr_pkg::POS_SERIAL) begin
          run_hash_nxt = run_hash_r * sawr_pkg::HASH_MUL + {{24{b[7]}}, b};
        end
        if (byte_pos_r >= sawr_pkg::POS_HDR && hdr_serial_r == expected_serial_r) begin
          if (first_pkt && byte_pos_r < sawr_pkg::POS_SIZE_END) begin
            size_shift_nxt = {size_shift_r[55:0], b};
          end else begin
            pay_emit = 1'b1;
          end
        end
        byte_pos_nxt = byte_pos_r + sawr_pkg::POS_W'(1);
      end

      if (item.end_of_datagram) begin
        cnt     = byte_pos_nxt;
        len_bad = (cnt < sawr_pkg::POS_HDR) ||
                  ({3'b000, cnt} != ({1'b0, hdr_len_nxt} + 17'(sawr_pkg::HDR_BYTES)));
        if (len_bad) begin
          verd_item.verdict = sawr_pkg::VERD_BAD_LENGTH;
        end else if (hdr_serial_nxt == expected_serial_r) begin
          if (run_hash_nxt != hdr_hash_nxt) begin
            verd_item.verdict = sawr_pkg::VERD_BAD_HASH;
          end else begin
            verd_item.verdict    = sawr_pkg::VERD_ACCEPTED;
            verd_item.commit     = 1'b1;
            verd_item.ack_valid  = 1'b1;
            verd_item.ack_serial = hdr_serial_nxt;
            verd_item.ack_copies = sawr_pkg::ACK_COPIES_ONE;
            if (first_pkt) begin
              ann_size_nxt       = size_shift_nxt;
              awaiting_first_nxt = 1'b0;
            end else begin
              delivered_nxt = delivered_r + {48'd0, hdr_len_nxt};
            end
            done = delivered_nxt == ann_size_nxt;
            if (done) begin
              verd_item.ack_copies = sawr_pkg::ACK_COPIES_DONE;
              finished_nxt         = 1'b1;
            end else begin
              expected_serial_nxt = expected_serial_r + 16'd1;
            end
          end
        end else if (hdr_serial_nxt < expected_serial_r) begin
          if (({1'b0, hdr_serial_nxt} + 17'd1) == {1'b0, expected_serial_r}) begin
            verd_item.verdict    = sawr_pkg::VERD_DUP_REACKED;
            verd_item.ack_valid  = 1'b1;
            verd_item.ack_serial = hdr_serial_nxt;
            verd_item.ack_copies = sawr_pkg::ACK_COPIES_ONE;
          end else begin
            verd_item.verdict = sawr_pkg::VERD_DUP_IGNORED;
          end
        end else begin
          verd_item.verdict = sawr_pkg::VERD_AHEAD;
        end
        verd_item.announced_size = ann_size_nxt;
        verd_item.transfer_done  = done;
        byte_pos_nxt   = '0;
        run_hash_nxt   = '0;
        size_shift_nxt = '0;
      end
    end

    pay_item.last_of_run = !(take && !finished_r && item.end_of_datagram);

    push = '0;
    if (take && !finished_r) begin
      if (pay_emit && item.end_of_datagram) begin
        push.n     = 2'd2;
        push.item0 = pay_item;
        push.item1 = verd_item;
      end else if (pay_emit) begin
        push.n     = 2'd1;
        push.item0 = pay_item;
      end else if (item.end_of_datagram) begin
        push.n     = 2'd1;
        push.item0 = verd_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_serial_r <= '0;
      awaiting_first_r  <= 1'b1;
      ann_size_r        <= '0;
      delivered_r       <= '0;
      byte_pos_r        <= '0;
      run_hash_r        <= '0;
      hdr_hash_r        <= '0;
      hdr_serial_r      <= '0;
      hdr_len_r         <= '0;
      size_shift_r      <= '0;
      finished_r        <= 1'b0;
    end else begin
      expected_serial_r <= expected_serial_nxt;
      awaiting_first_r  <= awaiting_first_nxt;
      ann_size_r        <= ann_size_nxt;
      delivered_r       <= delivered_nxt;
      byte_pos_r        <= byte_pos_nxt;
      run_hash_r        <= run_hash_nxt;
      hdr_hash_r        <= hdr_hash_nxt;
      hdr_serial_r      <= hdr_serial_nxt;
      hdr_len_r         <= hdr_len_nxt;
      size_shift_r      <= size_shift_nxt;
      finished_r        <= finished_nxt;
    end
  end

endmodule

// ----- src/sawr_outq.sv -----
// sawr_outq: four-entry result queue, takes up to two results a cycle and drains one
// depends on sawr_pkg
`timescale 1ns / 1ps

module sawr_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sawr_pkg::core_push_t push,
  input  logic                 pop,
  output logic                 out_valid,
  output sawr_pkg::out_item_t  out_data,
  output sawr_pkg::outq_stat_t stat
);

  sawr_pkg::out_item_t                 mem_r [sawr_pkg::OUTQ_DEPTH];
  logic [sawr_pkg::OUTQ_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [sawr_pkg::OUTQ_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sawr_pkg::OUTQ_CNT_W-1:0]     count_r, count_nxt;
  logic [sawr_pkg::OUTQ_PTR_W-1:0]     wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + sawr_pkg::OUTQ_PTR_W'(1);
  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];

  assign stat.count = count_r;
  assign stat.room2 = count_r <= sawr_pkg::OUTQ_CNT_W'(sawr_pkg::OUTQ_DEPTH - 2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.n;
    rd_ptr_nxt = rd_ptr_r + {{(sawr_pkg::OUTQ_PTR_W-1){1'b0}}, pop};
    count_nxt  = count_r + {1'b0, push.n} - {{(sawr_pkg::OUTQ_CNT_W-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.item0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- src/stop_and_wait_packet_receiver_unit.sv -----
// stop_and_wait_packet_receiver_unit: top level, input register, parse core and result queue
// depends on sawr_pkg, sawr_core, sawr_outq
`timescale 1ns / 1ps
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    sawr_pkg::in_item_t  (rx_byte, end_of_datagram)
//   out_     output     out_valid / out_stall  sawr_pkg::out_item_t (verdict item or byte item)
//
// one datagram byte per cycle while in_stall is low; a byte enters the input register and is
// parsed once the queue has room for two; its results are registered in the queue ahead of the
// output port; a closing byte with payload yields two results; the output drains one per cycle
// unless out_stall, so a sustained stall on out_ raises in_stall once the four-entry queue holds
// more than two; reset is synchronous, active low, and needs no clearing pass

module stop_and_wait_packet_receiver_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sawr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sawr_pkg::out_item_t out_data
);

  sawr_pkg::in_item_t   in_r;
  logic                 in_vld_r, in_vld_nxt;
  logic                 core_take;
  logic                 in_xfer;
  logic                 pop;
  sawr_pkg::core_push_t push;
  sawr_pkg::outq_stat_t stat;

  assign core_take  = in_vld_r && stat.room2;
  assign in_stall   = in_vld_r && !stat.room2;
  assign in_xfer    = in_valid && !in_stall;
  assign pop        = out_valid && !out_stall;
  assign in_vld_nxt = in_xfer || (in_vld_r && !core_take);

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  sawr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (core_take),
    .item  (in_r),
    .push  (push)
  );

  sawr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= sawr_pkg::OUTQ_CNT_W'(sawr_pkg::OUTQ_DEPTH))
    else $error("result queue over capacity");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> stat.room2)
    else $error("results pushed without room");

  a_byte_item_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind != sawr_pkg::KIND_VERDICT |->
      !out_data.commit && !out_data.ack_valid && !out_data.transfer_done)
    else $error("byte item carries verdict fields");

  a_done_copies: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.transfer_done |->
      out_data.ack_copies == sawr_pkg::ACK_COPIES_DONE && out_data.last_of_run)
    else $error("completing verdict malformed");
`endif

endmodule

// ----- tb/tb_stop_and_wait_packet_receiver_unit.sv -----
`timescale 1ns / 1ps
// tb_stop_and_wait_packet_receiver_unit: self-checking bench for the stop-and-wait receiver
// feeds crafted and random datagrams byte by byte and checks each result against a
// behavioural copy of the receiver; depends on sawr_pkg and stop_and_wait_packet_receiver_unit

module tb_stop_and_wait_packet_receiver_unit;
  import sawr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT        = 60;
  localparam int RANDOM_BYTES   = 600;
  localparam int HASH_SPAN      = MAX_PAYLOAD + HDR_BYTES - 4;
  localparam bit [3:0] DONE_COPIES = (1 + EXTRA_ACKS > 15) ? 4'd15 : 4'(1 + EXTRA_ACKS);

  typedef bit [7:0] byteq_t[$];

  typedef struct {
    bit [15:0] exp_serial;
    bit        awaiting;
    bit [63:0] ann_size;
    bit [63:0] delivered;
    bit [13:0] pos;
    bit [31:0] hash;
    bit [31:0] hdr_hash;
    bit [15:0] hdr_serial;
    bit [15:0] hdr_len;
    bit [63:0] size_acc;
    bit        done;
  } link_state_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item_a;
    out_item_t  item_b;
  } byte_results_t;

  typedef struct {
    in_item_t item;
    bit       drain;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  stim_t       datagram_bytes[$];
  out_item_t   due_results[$];
  link_state_t model_link;
  link_state_t plan_link;

  bit in_taken = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  stop_and_wait_packet_receiver_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic link_state_t fresh_link();
    link_state_t st;
    st = '{default: '0};
    st.awaiting = 1'b1;
    return st;
  endfunction

  function automatic byte_results_t receive_byte(inout link_state_t st, input in_item_t x);
    byte_results_t r;
    out_item_t     v;
    bit [7:0]      b;
    bit            first_pkt;
    r = '0;
    b = x.rx_byte;
    if (st.done) return r;
    if (st.pos < POS_CAP) begin
      first_pkt = st.awaiting && (st.exp_serial == 16'd0);
      if (st.pos < POS_SERIAL) st.hdr_hash = {st.hdr_hash[23:0], b};
      else if (st.pos < POS_LENGTH) st.hdr_serial = {st.hdr_serial[7:0], b};
      else if (st.pos < POS_HDR) st.hdr_len = {st.hdr_len[7:0], b};
      if (st.pos >= POS_SERIAL) st.hash = st.hash * HASH_MUL + {{24{b[7]}}, b};
      if (st.pos >= POS_HDR && st.hdr_serial == st.exp_serial) begin
        if (first_pkt && st.pos < POS_SIZE_END) begin
          st.size_acc = {st.size_acc[55:0], b};
        end else begin
          v = '0;
          v.item_kind = first_pkt ? KIND_NAME : KIND_PAYLOAD;
          v.out_byte = b;
          r.item_a = v;
          r.cnt = 2'd1;
        end
      end
      st.pos = st.pos + 14'd1;
    end
    if (x.end_of_datagram) begin
      v = '0;
      v.item_kind = KIND_VERDICT;
      if (st.pos < POS_HDR || int'(st.pos) != int'(st.hdr_len) + HDR_BYTES) begin
        v.verdict = VERD_BAD_LENGTH;
      end else if (st.hdr_serial == st.exp_serial) begin
        if (st.hash != st.hdr_hash) begin
          v.verdict = VERD_BAD_HASH;
        end else begin
          v.verdict = VERD_ACCEPTED;
          v.commit = 1'b1;
          v.ack_valid = 1'b1;
          v.ack_serial = st.hdr_serial;
          v.ack_copies = 4'd1;
          if (st.awaiting && st.exp_serial == 16'd0) begin
            st.ann_size = st.size_acc;
            st.awaiting = 1'b0;
          end else begin
            st.delivered = st.delivered + 64'(st.hdr_len);
          end
          if (st.delivered == st.ann_size) begin
            v.ack_copies = DONE_COPIES;
            v.transfer_done = 1'b1;
            st.done = 1'b1;
          end else begin
            st.exp_serial = st.exp_serial + 16'd1;
          end
        end
      end else if (st.hdr_serial < st.exp_serial) begin
        if (int'(st.hdr_serial) + 1 == int'(st.exp_serial)) begin
          v.verdict = VERD_DUP_REACKED;
          v.ack_valid = 1'b1;
          v.ack_serial = st.hdr_serial;
          v.ack_copies = 4'd1;
        end else begin
          v.verdict = VERD_DUP_IGNORED;
        end
      end else begin
        v.verdict = VERD_AHEAD;
      end
      v.announced_size = st.ann_size;
      if (r.cnt == 2'd0) r.item_a = v;
      else r.item_b = v;
      r.cnt = r.cnt + 2'd1;
      st.pos = '0;
      st.hash = '0;
      st.size_acc = '0;
    end
    if (r.cnt == 2'd1) r.item_a.last_of_run = 1'b1;
    else if (r.cnt == 2'd2) r.item_b.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic string show_item(out_item_t r);
    return $sformatf("kind %0d byte %02h verdict %0d commit %0b ack %0b serial %04h %s",
                     r.item_kind, r.out_byte, r.verdict, r.commit, r.ack_valid, r.ack_serial,
                     $sformatf("copies %0d size %0h done %0b last %0b", r.ack_copies,
                               r.announced_size, r.transfer_done, r.last_of_run));
  endfunction

  function automatic byteq_t rand_bytes(int n);
    byteq_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  task automatic send_dgram(byteq_t body, bit drain);
    stim_t         s;
    byte_results_t ignored;
    foreach (body[i]) begin
      s.item.rx_byte = body[i];
      s.item.end_of_datagram = (i == body.size() - 1);
      s.drain = drain && (i == 0);
      datagram_bytes.push_back(s);
      ignored = receive_byte(plan_link, s.item);
    end
  endtask

  task automatic send_pkt(bit [15:0] serial, bit [15:0] len_field, byteq_t payload,
                          bit corrupt, bit drain);
    byteq_t    tail;
    byteq_t    body;
    bit [31:0] h;
    tail.push_back(serial[15:8]);
    tail.push_back(serial[7:0]);
    tail.push_back(len_field[15:8]);
    tail.push_back(len_field[7:0]);
    foreach (payload[i]) tail.push_back(payload[i]);
    h = '0;
    for (int i = 0; i < tail.size() && i < HASH_SPAN; i++)
      h = h * HASH_MUL + {{24{tail[i][7]}}, tail[i]};
    if (corrupt) h = h ^ (32'd1 << $urandom_range(31, 0));
    for (int i = 3; i >= 0; i--) body.push_back(h[8*i +: 8]);
    foreach (tail[i]) body.push_back(tail[i]);
    send_dgram(body, drain);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (datagram_bytes.size() != 0 &&
          !(datagram_bytes[0].drain && due_results.size() != 0) &&
          ((bytes_sent >= 250 && bytes_sent < 450) || $urandom_range(99, 0) >= 19)) begin
        in_data <= datagram_bytes[0].item;
        in_valid <= 1'b1;
        void'(datagram_bytes.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, with one long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_used && results_seen >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (results_seen >= 120 && results_seen < 240) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99, 0) < 19);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t     want;
    byte_results_t fresh;
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", show_item(out_data));
        end else begin
          want = due_results.pop_front();
          if (out_data.item_kind !== want.item_kind || out_data.out_byte !== want.out_byte ||
              out_data.verdict !== want.verdict || out_data.commit !== want.commit ||
              out_data.ack_valid !== want.ack_valid ||
              out_data.ack_serial !== want.ack_serial ||
              out_data.ack_copies !== want.ack_copies ||
              out_data.announced_size !== want.announced_size ||
              out_data.transfer_done !== want.transfer_done ||
              out_data.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch\n  expected %s\n  actual   %s", show_item(want),
                       show_item(out_data));
            end
          end
        end
      end
      if (in_taken) begin
        bytes_sent++;
        fresh = receive_byte(model_link, in_data);
        if (fresh.cnt >= 2'd1) due_results.push_back(fresh.item_a);
        if (fresh.cnt == 2'd2) due_results.push_back(fresh.item_b);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int        pick;
    int        len;
    int        pkts;
    int        start;
    bit        pause;
    bit [15:0] serial;
    bit [15:0] field;
    bit [63:0] size_total;
    bit [63:0] rem;
    byteq_t    pl;
    model_link = fresh_link();
    plan_link = fresh_link();
    size_total = 64'd200 + 64'($urandom_range(100, 0));

    // runts
    send_dgram('{8'hFF}, 1'b0);
    send_dgram('{8'h00, 8'h80, 8'h7F, 8'hFF, 8'h01, 8'h02, 8'h03}, 1'b0);
    // first packet attempts: short size field with bad hash, then bad length with name bytes
    send_pkt(16'd0, 16'd5, rand_bytes(5), 1'b1, 1'b0);
    send_pkt(16'd0, 16'd12, rand_bytes(10), 1'b0, 1'b0);
    // ahead of the expected serial
    send_pkt(16'd3, 16'd0, rand_bytes(0), 1'b0, 1'b0);
    send_pkt(16'hFFFF, 16'd2, rand_bytes(2), 1'b0, 1'b0);
    // first accepted packet: size then name
    pl.delete();
    for (int i = 7; i >= 0; i--) pl.push_back(size_total[8*i +: 8]);
    pl = {pl, rand_bytes(4)};
    send_pkt(16'd0, 16'd12, pl, 1'b0, 1'b0);
    // duplicates and an empty packet
    send_pkt(16'd0, 16'd3, rand_bytes(3), 1'b0, 1'b0);
    send_pkt(16'd1, 16'd0, rand_bytes(0), 1'b0, 1'b0);
    send_pkt(16'd0, 16'd1, rand_bytes(1), 1'b0, 1'b0);
    send_pkt(16'd1, 16'd0, rand_bytes(0), 1'b0, 1'b0);
    send_pkt(16'd2, 16'd4, '{8'h00, 8'hFF, 8'h7F, 8'h80}, 1'b0, 1'b0);

    start = datagram_bytes.size();
    pkts = 0;
    while (datagram_bytes.size() - start < RANDOM_BYTES) begin
      pick = $urandom_range(99, 0);
      rem = size_total - plan_link.delivered;
      len = $urandom_range(20, 0);
      if (64'(len) >= rem) len = int'(rem) - 1;
      pkts++;
      pause = (pkts == 10);
      serial = plan_link.exp_serial;
      if (pick < 45) begin
        send_pkt(serial, 16'(len), rand_bytes(len), 1'b0, pause);
      end else if (pick < 57) begin
        send_pkt(serial, 16'(len), rand_bytes(len), 1'b1, pause);
      end else if (pick < 67) begin
        send_pkt(serial - 16'd1, 16'(len), rand_bytes(len), 1'b0, pause);
      end else if (pick < 73) begin
        send_pkt(16'($urandom_range(int'(serial) - 2, 0)), 16'(len), rand_bytes(len),
                 1'b0, pause);
      end else if (pick < 78) begin
        send_pkt(serial + 16'($urandom_range(300, 1)), 16'(len), rand_bytes(len), 1'b0, pause);
      end else if (pick < 88) begin
        if (len > 0 && $urandom_range(1, 0) == 1) field = 16'(len - $urandom_range(len, 1));
        else field = 16'(len + $urandom_range(6, 1));
        if ($urandom_range(1, 0) == 1) serial = serial - 16'd1;
        send_pkt(serial, field, rand_bytes(len), 1'b0, pause);
      end else if (pick < 94) begin
        send_dgram(rand_bytes($urandom_range(7, 1)), pause);
      end else begin
        send_dgram(rand_bytes($urandom_range(30, 8)), pause);
      end
    end

    // completing packet, then input that must be ignored
    rem = size_total - plan_link.delivered;
    send_pkt(plan_link.exp_serial, 16'(rem), rand_bytes(int'(rem)), 1'b0, 1'b0);
    send_dgram(rand_bytes(12), 1'b0);
    send_dgram(rand_bytes(3), 1'b0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (datagram_bytes.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
